FILE: hdl/svd_pkg.sv
// ----------------------------------------------------------------------------
// svd_pkg
// Types and constants shared by the svpwm duty calculator modules.
// ----------------------------------------------------------------------------
package svd_pkg;

  localparam int unsigned VW   = 16;  // phase and bus voltage width
  localparam int unsigned QuoW = 14;  // quotient bits below saturation
  localparam int unsigned NPH  = 3;   // phases

  localparam logic [15:0] DUTY_HALF = 16'd16384;
  localparam logic [15:0] DUTY_FULL = 16'd32768;

  typedef struct packed {
    logic signed [15:0] phase_a_voltage;
    logic signed [15:0] phase_b_voltage;
    logic signed [15:0] phase_c_voltage;
    logic        [15:0] bus_voltage;
  } in_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic        bus_zero_error;
  } out_t;

  // one phase lane of the divider chain
  typedef struct packed {
    logic [VW-1:0]   rem;
    logic [QuoW-1:0] quo;
    logic            neg;
    logic            sat;
  } phase_t;

  // everything handed from one cell to the next
  typedef struct packed {
    logic                    valid;
    logic                    err;
    logic [VW-1:0]           bus;
    phase_t [NPH-1:0]        ph;
  } stage_t;

endpackage

FILE: hdl/svd_prep.sv
// ----------------------------------------------------------------------------
// svd_prep
// Min-max zero sequence removal; splits each phase into sign, magnitude
// and an early saturation flag ahead of the divider chain.
// ----------------------------------------------------------------------------
module svd_prep import svd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  in_t    din,
  output stage_t dout
);

  logic signed [15:0] vmax;
  logic signed [15:0] vmin;
  stage_t             nxt;

  function automatic phase_t lane_prep(logic signed [15:0] v, logic signed [15:0] hi,
                                       logic signed [15:0] lo, logic [15:0] bus);
    logic signed [17:0] d;
    logic        [17:0] dn;
    logic        [15:0] mag;
    phase_t             p;
    d   = 18'(v) + 18'(v) - 18'(hi) - 18'(lo);
    dn  = -d;
    mag = d[17] ? dn[15:0] : d[15:0];
    p.neg = d[17];
    // mag >= bus means the quotient reaches a full half duty
    p.sat = (mag >= bus);
    p.rem = mag;
    p.quo = '0;
    return p;
  endfunction

  always_comb begin
    vmax = din.phase_a_voltage;
    vmin = din.phase_a_voltage;
    if (din.phase_b_voltage > vmax) vmax = din.phase_b_voltage;
    if (din.phase_c_voltage > vmax) vmax = din.phase_c_voltage;
    if (din.phase_b_voltage < vmin) vmin = din.phase_b_voltage;
    if (din.phase_c_voltage < vmin) vmin = din.phase_c_voltage;
    nxt.valid = in_valid;
    nxt.err   = (din.bus_voltage == '0);
    nxt.bus   = din.bus_voltage;
    nxt.ph[0] = lane_prep(din.phase_a_voltage, vmax, vmin, din.bus_voltage);
    nxt.ph[1] = lane_prep(din.phase_b_voltage, vmax, vmin, din.bus_voltage);
    nxt.ph[2] = lane_prep(din.phase_c_voltage, vmax, vmin, din.bus_voltage);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= nxt;
    end
  end

endmodule

FILE: hdl/svd_div_cell.sv
// ----------------------------------------------------------------------------
// svd_div_cell
// One restoring division step for all three phases, registered.
// ----------------------------------------------------------------------------
module svd_div_cell import svd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  stage_t din,
  output stage_t dout
);

  stage_t nxt;

  always_comb begin
    logic [VW:0] r2;
    logic [VW:0] diff;
    nxt = din;
    for (int i = 0; i < NPH; i++) begin
      r2   = {din.ph[i].rem, 1'b0};
      diff = r2 - {1'b0, din.bus};
      if (r2 >= {1'b0, din.bus}) begin
        nxt.ph[i].rem = diff[VW-1:0];
        nxt.ph[i].quo = {din.ph[i].quo[QuoW-2:0], 1'b1};
      end else begin
        nxt.ph[i].rem = r2[VW-1:0];
        nxt.ph[i].quo = {din.ph[i].quo[QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= nxt;
    end
  end

endmodule

FILE: hdl/svpwm_duty_calc.sv
// ----------------------------------------------------------------------------
// svpwm_duty_calc
// Min-max zero sequence space vector PWM duty calculator.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge where start is high; busy is
// always low, so a new request may follow in every cycle. The request
// carries three signed phase voltages and the bus voltage.
// Each request gives one result: three duties in units of 1/32768,
// floor((2v - max - min) * 16384 / bus) + 16384 clamped to 0..32768, and
// bus_zero_error, which forces all duties to zero when bus is zero.
// The steps are: min/max and magnitude in svd_prep, fourteen
// division cells (one quotient bit each, all phases in parallel), and a
// final register that folds sign, rounding and saturation into the duty.
// Throughput is one result per cycle; the cell chain is the bulk of the pipeline.
// done is high for exactly one cycle with result; the receiver cannot
// stall the block, so results must be taken when shown.
// Reset clears the valid bits of the chain and done; requests in flight
// are dropped.
// ----------------------------------------------------------------------------
module svpwm_duty_calc import svd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  request,
  output logic done,
  output out_t result
);

  stage_t chain [QuoW+1];
  out_t   result_next;

  assign busy = 1'b0;

  svd_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .din      (request),
    .dout     (chain[0])
  );

  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    svd_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  function automatic logic [15:0] lane_duty(phase_t p);
    logic [15:0] q;
    logic [15:0] d;
    q = {{(16-QuoW){1'b0}}, p.quo};
    if (p.neg) begin
      // floor of a negative quotient rounds the magnitude up
      d = p.sat ? 16'd0 : DUTY_HALF - q - {15'd0, (p.rem != '0)};
    end else begin
      d = p.sat ? DUTY_FULL : DUTY_HALF + q;
    end
    return d;
  endfunction

  always_comb begin
    stage_t s;
    s = chain[QuoW];
    result_next.bus_zero_error = s.err;
    result_next.duty_a = s.err ? 16'd0 : lane_duty(s.ph[0]);
    result_next.duty_b = s.err ? 16'd0 : lane_duty(s.ph[1]);
    result_next.duty_c = s.err ? 16'd0 : lane_duty(s.ph[2]);
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[QuoW].valid;
    end
  end

endmodule
